### rtl/nlsl_pkg.sv
// Package with the constants and types of the nearest-length speed limit lookup.
package nlsl_pkg;

  localparam int unsigned EntriesDefault = 16;

  localparam int unsigned LenW   = 15;
  localparam int unsigned SpdW   = 16;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  localparam logic [LenW-1:0] SpeedMaxReset = 15'h7FFF;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StScan,
    StDone
  } state_e;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [SpdW-1:0] spd;
  } entry_t;

endpackage

### rtl/nearest_length_speed_limit_lookup.sv
// Top level of the nearest-length speed limit lookup with its entry memory and scan sequencer.
//
// Input items arrive on the s_axis channel; s_axis_tuser selects a table write (0) or a
// query (1). A write stores one entry in the cycle it is accepted and gives no result.
// A query scans the entry memory from index 0 up to the first zero length or the last
// entry, one entry per cycle through the single read port, and keeps the entry with the
// smallest length difference, the lowest index winning ties. One result then appears on
// the m_axis channel: the chosen speed limit saturated at the configured maximum, the
// found flag on m_axis_tuser and the entry index.
// A write leaves the block idle and ready for the next item. A query passes through the
// setup state StRead, the scan state StScan once per scanned entry (at most ENTRIES) and
// the state StDone that loads the output register; no new item is taken before that load.
// The output register holds a finished result while the receiver stalls; the next item
// is still accepted, and a further query waits only before loading its result.
// Reset empties the table at once through per-entry valid bits and sets the maximum to 32767.
// The user sets the maximum via cfg_we_i/cfg_wdata_i only while idle; it is not enforced.
module nearest_length_speed_limit_lookup
  import nlsl_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LenW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // entry_index[3:0], entry_length[18:4], entry_speed_limit[34:19], query_length[49:35]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // mode[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // speed_limit[15:0], found_index[19:16]
  output logic [OutDataW-1:0] m_axis_tdata,
  // found[0]
  output logic                m_axis_tuser
);

  localparam int unsigned AddrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(ENTRIES - 1);

  logic [IdxW-1:0]        in_index;
  logic [LenW-1:0]        in_length;
  logic signed [SpdW-1:0] in_speed;
  logic [LenW-1:0]        in_query;

  assign in_index  = s_axis_tdata[3:0];
  assign in_length = s_axis_tdata[18:4];
  assign in_speed  = s_axis_tdata[34:19];
  assign in_query  = s_axis_tdata[49:35];

  state_e state_q, state_d;

  logic [LenW-1:0]     max_q;
  logic [ENTRIES-1:0]  valid_q;
  entry_t              mem [ENTRIES];
  entry_t              rd_q;
  logic                rd_valid_q;
  logic [AddrW-1:0]    rd_addr;

  logic [AddrW-1:0]    ptr_q;
  logic [LenW-1:0]     query_q;
  logic                hit_q;
  logic [AddrW-1:0]    best_idx_q;
  logic [LenW-1:0]     best_diff_q;
  logic [SpdW-1:0]     best_spd_q;

  logic                out_valid_q;
  logic [SpdW-1:0]     out_spd_q;
  logic                out_found_q;
  logic [IdxW-1:0]     out_idx_q;

  logic                in_xfer;
  logic                load_out;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [AddrW+IdxW-1:0] wide_index;
  logic [AddrW+IdxW-1:0] wide_best;

  logic [LenW-1:0]     cur_len;
  logic [LenW-1:0]     cur_diff;
  logic                cur_end;
  logic                cur_better;
  logic                scan_last;
  logic [SpdW-1:0]     sat_spd;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign wide_index = {{AddrW{1'b0}}, in_index};
  assign wr_addr    = wide_index[AddrW-1:0];
  assign wr_en      = in_xfer && (s_axis_tuser == ModeWrite)
                      && (wide_index < (AddrW+IdxW)'(ENTRIES));

  assign cur_len    = rd_valid_q ? rd_q.len : '0;
  assign cur_end    = (cur_len == '0);
  assign cur_diff   = (cur_len >= query_q) ? (cur_len - query_q) : (query_q - cur_len);
  assign cur_better = !cur_end && (!hit_q || (cur_diff < best_diff_q));
  assign scan_last  = cur_end || (ptr_q == LastAddr);

  assign sat_spd = !hit_q ? {1'b0, max_q}
                 : ($signed(best_spd_q) > $signed({1'b0, max_q})) ? {1'b0, max_q}
                 : best_spd_q;
  assign wide_best = {{IdxW{1'b0}}, best_idx_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer && (s_axis_tuser == ModeQuery)) begin
          state_d = StRead;
        end
      end
      StRead: state_d = StScan;
      StScan: begin
        if (scan_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    rd_addr       = '0;
    unique case (state_q)
      StIdle: s_axis_tready = 1'b1;
      StRead: rd_addr = '0;
      StScan: begin
        if (!scan_last) begin
          rd_addr = ptr_q + AddrW'(1);
        end
      end
      StDone: load_out = !out_valid_q || m_axis_tready;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      max_q       <= SpeedMaxReset;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_xfer) begin
        hit_q <= 1'b0;
      end else if ((state_q == StScan) && cur_better) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{len: in_length, spd: in_speed};
    end
    rd_q       <= mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      query_q <= in_query;
      ptr_q   <= '0;
    end else if ((state_q == StScan) && !scan_last) begin
      ptr_q <= ptr_q + AddrW'(1);
    end
    if ((state_q == StScan) && cur_better) begin
      best_idx_q  <= ptr_q;
      best_diff_q <= cur_diff;
      best_spd_q  <= rd_q.spd;
    end
    if (load_out) begin
      out_spd_q   <= sat_spd;
      out_found_q <= hit_q;
      out_idx_q   <= hit_q ? wide_best[IdxW-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_idx_q, out_spd_q};
  assign m_axis_tuser  = out_found_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[19:16] == '0))
    else $error("result without a match carries a nonzero index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (ptr_q <= LastAddr))
    else $error("scan pointer beyond the table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (s_axis_tuser == ModeQuery)) |=> (state_q == StRead && !hit_q))
    else $error("query did not start a fresh scan");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the nearest-length speed limit lookup.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nlsl_pkg::*;

  localparam int Entries       = 16;
  localparam int PadW          = InDataW - IdxW - 2 * LenW - SpdW;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;
  localparam int PhaseItems    = 240;

  typedef struct packed {
    logic            mode;
    logic [IdxW-1:0] idx;
    logic [LenW-1:0] len;
    logic [SpdW-1:0] spd;
    logic [LenW-1:0] qlen;
  } req_t;

  typedef struct packed {
    logic [SpdW-1:0] speed;
    logic            found;
    logic [IdxW-1:0] idx;
  } limit_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [LenW-1:0]     cfg_wdata_i = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  req_t            item_queue[$];
  limit_t          limit_q[$];
  req_t            cur_item;
  limit_t          got;
  limit_t          want;
  logic [LenW-1:0] len_tab[Entries];
  logic [SpdW-1:0] spd_tab[Entries];
  logic [LenW-1:0] speed_max = SpeedMaxReset;
  logic [LenW-1:0] gen_len[Entries];
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  logic            hold_armed = 1'b0;
  int              hold_cnt = 0;
  int              n_queued = 0;
  int              n_err = 0;
  int              quiet_cycles = 0;

  nearest_length_speed_limit_lookup #(
    .ENTRIES(Entries)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic limit_t nearest_limit(logic [LenW-1:0] qlen);
    limit_t r;
    int     best_diff;
    int     d;
    int     s;
    r.found = 1'b0;
    r.idx = '0;
    r.speed = {1'b0, speed_max};
    best_diff = 0;
    for (int i = 0; i < Entries; i++) begin
      if (len_tab[i] == '0) break;
      d = int'(len_tab[i]) - int'(qlen);
      if (d < 0) d = -d;
      if (!r.found || d < best_diff) begin
        r.found = 1'b1;
        r.idx = IdxW'(i);
        best_diff = d;
      end
    end
    if (r.found) begin
      s = int'($signed(spd_tab[r.idx]));
      if (s > int'(speed_max)) s = int'(speed_max);
      r.speed = s[SpdW-1:0];
    end
    return r;
  endfunction

  function automatic void apply_transfer(req_t r);
    if (r.mode == ModeWrite) begin
      len_tab[r.idx] = r.len;
      spd_tab[r.idx] = r.spd;
    end else begin
      limit_q.push_back(nearest_limit(r.qlen));
    end
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    case ($urandom_range(4))
      0: return LenW'($urandom_range(1, 64));
      1: return $urandom_range(1) ? LenW'(1) : LenW'(32767);
      default: return LenW'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic [SpdW-1:0] rand_speed();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return SpdW'(int'(speed_max) + $urandom_range(0, 8) - 4);
      default: return SpdW'($urandom);
    endcase
  endfunction

  function automatic logic [LenW-1:0] pick_qlen();
    int v;
    int a;
    int b;
    a = $urandom_range(Entries - 1);
    b = $urandom_range(Entries - 1);
    case ($urandom_range(3))
      0: v = $urandom_range(32767);
      1: v = int'(gen_len[a]);
      2: v = int'(gen_len[a]) + $urandom_range(0, 8) - 4;
      default: v = (int'(gen_len[a]) + int'(gen_len[b])) / 2;
    endcase
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return LenW'(v);
  endfunction

  task automatic push_write(int idx, logic [LenW-1:0] len, logic [SpdW-1:0] spd);
    req_t r;
    r.mode = ModeWrite;
    r.idx = IdxW'(idx);
    r.len = len;
    r.spd = spd;
    r.qlen = LenW'($urandom);
    gen_len[idx] = len;
    item_queue.push_back(r);
    n_queued++;
  endtask

  task automatic push_query(logic [LenW-1:0] qlen);
    req_t r;
    r.mode = ModeQuery;
    r.idx = IdxW'($urandom);
    r.len = LenW'($urandom);
    r.spd = SpdW'($urandom);
    r.qlen = qlen;
    item_queue.push_back(r);
    n_queued++;
  endtask

  task automatic fill_random(int count);
    int stop;
    int n;
    int k;
    stop = n_queued + count;
    while (n_queued < stop) begin
      k = $urandom_range(99);
      if (k < 60) begin
        n = $urandom_range(Entries);
        for (int i = 0; i < n; i++) push_write(i, rand_len(), rand_speed());
        if (n < Entries) push_write(n, '0, rand_speed());
        repeat ($urandom_range(1, 6)) push_query(pick_qlen());
      end else if (k < 80) begin
        push_write($urandom_range(Entries - 1), rand_len(), rand_speed());
        repeat ($urandom_range(1, 3)) push_query(pick_qlen());
      end else if ($urandom_range(1)) begin
        push_write($urandom_range(Entries - 1),
                   $urandom_range(3) ? rand_len() : LenW'(0), SpdW'($urandom));
      end else begin
        push_query(LenW'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (item_queue.size() != 0 || s_tvalid || limit_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [LenW-1:0] max_val, int send_pct, int rx_pct, bit hold);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= max_val;
    speed_max = max_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_idle_pct <= send_pct;
    stall_pct <= rx_pct;
    if (hold) hold_armed <= 1'b1;
    fill_random(PhaseItems);
  endtask

  // Driver: a transfer is taken when tvalid and tready are both high at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_transfer(cur_item);
      end
      if (!s_tvalid || s_tready) begin
        if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = item_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {{PadW{1'b0}}, cur_item.qlen, cur_item.spd, cur_item.len, cur_item.idx};
          s_tuser <= cur_item.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.speed = m_tdata[SpdW-1:0];
        got.idx = m_tdata[SpdW+IdxW-1:SpdW];
        got.found = m_tuser;
        if (limit_q.size() == 0) begin
          $error("result transfer with no pending query");
          n_err++;
        end else begin
          want = limit_q.pop_front();
          if (got.speed !== want.speed) begin
            $error("speed_limit: expected %0d, got %0d", $signed(want.speed),
                   $signed(got.speed));
            n_err++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            n_err++;
          end
          if (got.idx !== want.idx) begin
            $error("found_index: expected %0d, got %0d", want.idx, got.idx);
            n_err++;
          end
        end
      end
      if (hold_armed && hold_cnt < HoldCycles) begin
        hold_cnt++;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < Entries; i++) begin
      len_tab[i] = '0;
      spd_tab[i] = '0;
      gen_len[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Queries on an empty table, then nearest, tie and end-marker cases.
    push_query(LenW'(0));
    push_query(LenW'(32767));
    push_write(0, LenW'(32767), 16'h7FFF);
    push_query(LenW'(0));
    push_query(LenW'(32767));
    push_write(1, LenW'(2), 16'h8000);
    push_query(LenW'(0));
    push_write(2, LenW'(16384), 16'hFFFF);
    push_write(3, LenW'(16384), 16'd5);
    push_query(LenW'(16384));
    push_query(LenW'(8193));
    push_write(4, LenW'(0), 16'd77);
    push_write(5, LenW'(100), 16'd100);
    push_query(LenW'(100));
    push_write(0, LenW'(0), 16'd0);
    push_query(LenW'(2));

    run_phase(LenW'(32767), 0, 0, 1'b0);
    run_phase(LenW'(0), 48, 0, 1'b0);
    run_phase(LenW'(1), 0, 48, 1'b0);
    run_phase(LenW'($urandom_range(2, 32766)), 19, 19, 1'b0);
    run_phase(LenW'(16383), 0, 0, 1'b1);
    run_phase(LenW'(32767), 19, 19, 1'b0);

    wait_drained();
    if (n_err == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/nlsl_pkg.sv
rtl/nearest_length_speed_limit_lookup.sv
verif/tb_top.sv
